// File: sv/keyframe_vector_interpolator_assert.svh
// Assertion macros used by the kvi_back module.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KVI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KVI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/kvi_pkg.sv
`default_nettype none
package kvi_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int FRAC_BITS = 16;
    localparam int ADDR_W    = $clog2(MAX_KEYS);
    localparam int KCNT_W    = 7;
    localparam int QUOT_W    = 32 + FRAC_BITS;
    localparam int SUM_W     = 64 - FRAC_BITS + 1;
    localparam int TERM_W    = 41;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] ST_INTERP    = 3'd0;
    localparam logic [2:0] ST_SINGLE    = 3'd1;
    localparam logic [2:0] ST_FALLBACK  = 3'd2;
    localparam logic [2:0] ST_ZERO_SPAN = 3'd3;
    localparam logic [2:0] ST_WRITE_ACK = 3'd4;

    typedef struct packed {
        logic               op;
        logic [5:0]         idx;
        logic [31:0]        tval;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cmd_t;

    typedef struct packed {
        logic [31:0]        tval;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } key_t;

endpackage
`default_nettype wire

// File: sv/keyframe_vector_interpolator.sv
// Channel   Handshake              Payload
// input     push / full            op, key_index, key_time, key_x/y/z, query_time
// result    empty / pop            out_x/y/z, segment, status, saturated
// config    key_count_wr           key_count
//
// A key write is acknowledged in the cycle after it leaves the two-entry queue.
// A query runs a linear search over up to 63 keys, loads its segment, divides with the
// 48-bit restoring divider and multiplies each component in two halves; the divider and
// the search dominate. A single-key track answers without search or division.
// The queue keeps taking items while the engine works or a result waits, until it is full.
// Reset is asynchronous and active low; key_count returns to 1, keys are undefined.
`default_nettype none
module keyframe_vector_interpolator
    import kvi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               op,
    input  wire logic [5:0]         key_index,
    input  wire logic [31:0]        key_time,
    input  wire logic signed [31:0] key_x,
    input  wire logic signed [31:0] key_y,
    input  wire logic signed [31:0] key_z,
    input  wire logic [31:0]        query_time,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic [5:0]              segment,
    output logic [2:0]              status,
    output logic                    saturated,
    input  wire logic               key_count_wr,
    input  wire logic [KCNT_W-1:0]  key_count
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    kvi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .key_index  (key_index),
        .key_time   (key_time),
        .key_x      (key_x),
        .key_y      (key_y),
        .key_z      (key_z),
        .query_time (query_time),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take)
    );

    kvi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_count_wr (key_count_wr),
        .key_count    (key_count),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take),
        .empty        (empty),
        .pop          (pop),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .segment      (segment),
        .status       (status),
        .saturated    (saturated)
    );

endmodule
`default_nettype wire

// File: sv/kvi_front.sv
`default_nettype none
module kvi_front
    import kvi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               op,
    input  wire logic [5:0]         key_index,
    input  wire logic [31:0]        key_time,
    input  wire logic signed [31:0] key_x,
    input  wire logic signed [31:0] key_y,
    input  wire logic signed [31:0] key_z,
    input  wire logic [31:0]        query_time,
    output logic                    cmd_valid,
    output cmd_t                    cmd,
    input  wire logic               cmd_take
);

    cmd_t       cmd_in;
    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push_ok;
    logic       pop_ok;

    // A query carries its time in the same slot as a key time.
    always_comb
    begin
        cmd_in.op   = op;
        cmd_in.idx  = key_index;
        cmd_in.tval = (op == OP_QUERY) ? query_time : key_time;
        cmd_in.x    = key_x;
        cmd_in.y    = key_y;
        cmd_in.z    = key_z;
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign push_ok   = push && !full;
    assign pop_ok    = cmd_take && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push_ok && !pop_ok)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop_ok && !push_ok)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/kvi_div.sv
`default_nettype none
module kvi_div
    import kvi_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [QUOT_W-1:0] num,
    input  wire logic [31:0]       den,
    output logic                   done,
    output logic [QUOT_W-1:0]      quot
);

    localparam int CNT_W = $clog2(QUOT_W);

    logic [31:0]       rem_reg;
    logic [QUOT_W-1:0] quo_reg;
    logic [31:0]       den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [32:0]       shifted;
    logic [33:0]       diff;

    // Restoring division, one quotient bit per cycle.
    assign shifted = {rem_reg, quo_reg[QUOT_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign done    = done_reg;
    assign quot    = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[33] ? shifted[31:0] : diff[31:0];
            quo_reg <= {quo_reg[QUOT_W-2:0], !diff[33]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QUOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/kvi_back.sv
`default_nettype none
module kvi_back
    import kvi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               key_count_wr,
    input  wire logic [KCNT_W-1:0]  key_count,
    input  wire logic               cmd_valid,
    input  wire cmd_t               cmd,
    output logic                    cmd_take,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic [5:0]              segment,
    output logic [2:0]              status,
    output logic                    saturated
);

`include "keyframe_vector_interpolator_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_SINGLE, S_SRCH, S_LD0, S_LD1, S_DIV, S_MULL, S_MULH, S_ACC, S_OUT
    } state_t;

    localparam logic [TERM_W-1:0] TERM_CAP = TERM_W'(1) << (TERM_W - 1);

    state_t                 state_reg;
    logic [KCNT_W-1:0]      key_count_reg;
    key_t                   mem [MAX_KEYS];
    key_t                   mem_q_reg;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      last;
    logic [KCNT_W-1:0]      n_keys;
    logic                   hit;
    logic [ADDR_W-1:0]      j_reg;
    logic [ADDR_W-1:0]      seg_reg;
    logic [2:0]             status_reg;
    logic [31:0]            q_reg;
    logic [31:0]            t0_reg;
    logic signed [31:0]     start_reg [3];
    logic [31:0]            dmag_reg [3];
    logic                   dneg_reg [3];
    logic signed [31:0]     res_reg [3];
    logic                   fneg_reg;
    logic                   sat_reg;
    logic [QUOT_W-1:0]      fmag_reg;
    logic [1:0]             comp_reg;
    logic [63:0]            b_reg;
    logic [FRAC_BITS+31:0]  a_reg;
    logic                   out_valid_reg;
    logic signed [31:0]     out_x_reg;
    logic signed [31:0]     out_y_reg;
    logic signed [31:0]     out_z_reg;
    logic [5:0]             out_seg_reg;
    logic [2:0]             out_status_reg;
    logic                   out_sat_reg;

    logic [32:0]            span;
    logic [32:0]            offs;
    logic [31:0]            span_mag;
    logic [31:0]            offs_mag;
    logic [32:0]            delta [3];
    logic                   div_start;
    logic                   div_done;
    logic [QUOT_W-1:0]      div_quot;
    logic [31:0]            mul_a;
    logic [63:0]            prod;
    logic [SUM_W-1:0]       sum;
    logic [TERM_W-1:0]      term;
    logic signed [42:0]     acc_r;
    logic signed [31:0]     acc_val;
    logic                   acc_sat;
    logic                   mem_we;

    assign cmd_take  = (state_reg == S_IDLE) && cmd_valid && (!out_valid_reg || pop);
    assign mem_we    = cmd_take && (cmd.op == OP_WRITE)
                       && ({1'b0, cmd.idx} < KCNT_W'(MAX_KEYS));
    assign empty     = !out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign segment   = out_seg_reg;
    assign status    = out_status_reg;
    assign saturated = out_sat_reg;

    // Effective key count: zero acts as one, the count is capped at the track size.
    always_comb
    begin
        if (key_count_reg == '0)
        begin
            n_keys = KCNT_W'(1);
        end
        else if (key_count_reg > KCNT_W'(MAX_KEYS))
        begin
            n_keys = KCNT_W'(MAX_KEYS);
        end
        else
        begin
            n_keys = key_count_reg;
        end
        last = ADDR_W'(n_keys - KCNT_W'(1));
    end

    assign hit = (q_reg < mem_q_reg.tval);

    // The search reads the next candidate while the current one is compared.
    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                rd_addr = (last == '0) ? '0 : ADDR_W'(1);
            end
            S_SRCH:
            begin
                if (hit)
                begin
                    rd_addr = j_reg - ADDR_W'(1);
                end
                else if (j_reg == last)
                begin
                    rd_addr = '0;
                end
                else
                begin
                    rd_addr = j_reg + ADDR_W'(1);
                end
            end
            S_LD0:
            begin
                rd_addr = seg_reg + ADDR_W'(1);
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cmd.idx[ADDR_W-1:0]] <= '{tval: cmd.tval, x: cmd.x, y: cmd.y, z: cmd.z};
        end
        mem_q_reg <= mem[rd_addr];
    end

    // Segment setup: span, offset and the three component differences.
    always_comb
    begin
        span     = {1'b0, mem_q_reg.tval} - {1'b0, t0_reg};
        offs     = {1'b0, q_reg} - {1'b0, t0_reg};
        span_mag = span[32] ? 32'(-span) : span[31:0];
        offs_mag = offs[32] ? 32'(-offs) : offs[31:0];
        delta[0] = {mem_q_reg.x[31], mem_q_reg.x} - {start_reg[0][31], start_reg[0]};
        delta[1] = {mem_q_reg.y[31], mem_q_reg.y} - {start_reg[1][31], start_reg[1]};
        delta[2] = {mem_q_reg.z[31], mem_q_reg.z} - {start_reg[2][31], start_reg[2]};
    end

    assign div_start = (state_reg == S_LD1) && (span != '0);

    kvi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({offs_mag, {FRAC_BITS{1'b0}}}),
        .den   (span_mag),
        .done  (div_done),
        .quot  (div_quot)
    );

    // One 32x32 multiplier: low factor word first, then the high word.
    assign mul_a = (state_reg == S_MULH) ? 32'(fmag_reg[QUOT_W-1:32]) : fmag_reg[31:0];
    assign prod  = 64'(mul_a) * 64'(dmag_reg[comp_reg]);

    always_comb
    begin
        sum = (SUM_W'(a_reg[31:0]) << (32 - FRAC_BITS)) + SUM_W'(b_reg >> FRAC_BITS);
        if ((|a_reg[FRAC_BITS+31:32]) || (sum > SUM_W'(TERM_CAP)))
        begin
            term = TERM_CAP;
        end
        else
        begin
            term = sum[TERM_W-1:0];
        end
        if (fneg_reg != dneg_reg[comp_reg])
        begin
            acc_r = 43'(start_reg[comp_reg]) - $signed({2'b00, term});
        end
        else
        begin
            acc_r = 43'(start_reg[comp_reg]) + $signed({2'b00, term});
        end
        if (acc_r > 43'sh0_7FFF_FFFF)
        begin
            acc_val = 32'sh7FFF_FFFF;
            acc_sat = 1'b1;
        end
        else if (acc_r < -43'sh0_8000_0000)
        begin
            acc_val = -32'sh8000_0000;
            acc_sat = 1'b1;
        end
        else
        begin
            acc_val = acc_r[31:0];
            acc_sat = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_count_reg <= KCNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (key_count_wr)
            begin
                key_count_reg <= key_count;
            end
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        q_reg <= cmd.tval;
                        if (cmd.op == OP_WRITE)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_x_reg      <= '0;
                            out_y_reg      <= '0;
                            out_z_reg      <= '0;
                            out_seg_reg    <= '0;
                            out_status_reg <= ST_WRITE_ACK;
                            out_sat_reg    <= 1'b0;
                        end
                        else if (last == '0)
                        begin
                            state_reg <= S_SINGLE;
                        end
                        else
                        begin
                            j_reg     <= ADDR_W'(1);
                            state_reg <= S_SRCH;
                        end
                    end
                end
                S_SINGLE:
                begin
                    out_valid_reg  <= 1'b1;
                    out_x_reg      <= mem_q_reg.x;
                    out_y_reg      <= mem_q_reg.y;
                    out_z_reg      <= mem_q_reg.z;
                    out_seg_reg    <= '0;
                    out_status_reg <= ST_SINGLE;
                    out_sat_reg    <= 1'b0;
                    state_reg      <= S_IDLE;
                end
                S_SRCH:
                begin
                    if (hit)
                    begin
                        seg_reg    <= j_reg - ADDR_W'(1);
                        status_reg <= ST_INTERP;
                        state_reg  <= S_LD0;
                    end
                    else if (j_reg == last)
                    begin
                        seg_reg    <= '0;
                        status_reg <= ST_FALLBACK;
                        state_reg  <= S_LD0;
                    end
                    else
                    begin
                        j_reg <= j_reg + ADDR_W'(1);
                    end
                end
                S_LD0:
                begin
                    t0_reg       <= mem_q_reg.tval;
                    start_reg[0] <= mem_q_reg.x;
                    start_reg[1] <= mem_q_reg.y;
                    start_reg[2] <= mem_q_reg.z;
                    state_reg    <= S_LD1;
                end
                S_LD1:
                begin
                    sat_reg <= 1'b0;
                    if (span == '0)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_x_reg      <= start_reg[0];
                        out_y_reg      <= start_reg[1];
                        out_z_reg      <= start_reg[2];
                        out_seg_reg    <= 6'(seg_reg);
                        out_status_reg <= ST_ZERO_SPAN;
                        out_sat_reg    <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        fneg_reg <= offs[32] != span[32];
                        for (int c = 0; c < 3; c++)
                        begin
                            dneg_reg[c] <= delta[c][32];
                            dmag_reg[c] <= delta[c][32] ? 32'(-delta[c]) : delta[c][31:0];
                        end
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        fmag_reg  <= div_quot;
                        comp_reg  <= 2'd0;
                        state_reg <= S_MULL;
                    end
                end
                S_MULL:
                begin
                    b_reg     <= prod;
                    state_reg <= S_MULH;
                end
                S_MULH:
                begin
                    a_reg     <= prod[FRAC_BITS+31:0];
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    res_reg[comp_reg] <= acc_val;
                    sat_reg           <= sat_reg || acc_sat;
                    if (comp_reg == 2'd2)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= S_MULL;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg  <= 1'b1;
                    out_x_reg      <= res_reg[0];
                    out_y_reg      <= res_reg[1];
                    out_z_reg      <= res_reg[2];
                    out_seg_reg    <= 6'(seg_reg);
                    out_status_reg <= status_reg;
                    out_sat_reg    <= sat_reg;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `KVI_ASSERT_SAME(a_busy_out_free, state_reg != S_IDLE, !out_valid_reg,
        "result register occupied while a query is in progress")
    `KVI_ASSERT_NEXT(a_write_ack, cmd_take && cmd.op == OP_WRITE,
        out_valid_reg && out_status_reg == ST_WRITE_ACK, "key write not acknowledged")
    `KVI_ASSERT_SAME(a_div_in_state, div_done, state_reg == S_DIV,
        "divider finished outside the divide wait")

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import kvi_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [5:0]         seg;
        logic [2:0]         st;
        logic               sat;
    } lerp_res_t;

    typedef struct {
        bit          cfg;
        logic        op;
        logic [5:0]  idx;
        logic [31:0] t;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] q;
        bit          typed;
        lerp_res_t   res;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic op;
    logic [5:0] key_index;
    logic [31:0] key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic [31:0] query_time;
    logic empty;
    logic pop;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [5:0] segment;
    logic [2:0] status;
    logic saturated;
    logic key_count_wr;
    logic [KCNT_W-1:0] key_count;

    keyframe_vector_interpolator i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .op(op),
        .key_index(key_index),
        .key_time(key_time),
        .key_x(key_x),
        .key_y(key_y),
        .key_z(key_z),
        .query_time(query_time),
        .empty(empty),
        .pop(pop),
        .out_x(out_x),
        .out_y(out_y),
        .out_z(out_z),
        .segment(segment),
        .status(status),
        .saturated(saturated),
        .key_count_wr(key_count_wr),
        .key_count(key_count)
    );

    // Shadow copy of the key track and the count register.
    logic [31:0] trk_time [MAX_KEYS];
    logic [31:0] trk_x [MAX_KEYS];
    logic [31:0] trk_y [MAX_KEYS];
    logic [31:0] trk_z [MAX_KEYS];
    bit          slot_written [MAX_KEYS];
    logic [KCNT_W-1:0] trk_count;

    lerp_res_t   pending_res [$];
    dir_row_t    dir_rows [$];
    int          errors;
    int          checked;
    int          n_queries;
    int          n_writes;
    int          burst_left;
    longint      cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_count(logic [KCNT_W-1:0] c);
        int n;
        n = c;
        if (n < 1)
            n = 1;
        if (n > MAX_KEYS)
            n = MAX_KEYS;
        return n;
    endfunction

    function automatic longint clip_lerp(longint s, longint e, longint unsigned fm, bit fneg,
                                         inout bit sat);
        longint d;
        longint unsigned dm;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned term;
        longint r;
        bit neg;
        d = e - s;
        dm = (d < 0) ? longint'(-d) : d;
        neg = fneg ^ (d < 0);
        hi = (fm >> 32) * dm;
        lo = (fm & 64'hFFFF_FFFF) * dm;
        if (hi >= 64'h1_0000_0000)
            term = 64'd1 << 40;
        else
        begin
            term = (hi << (32 - FRAC_BITS)) + (lo >> FRAC_BITS);
            if (term > (64'd1 << 40))
                term = 64'd1 << 40;
        end
        r = neg ? s - longint'(term) : s + longint'(term);
        if (r > 64'sh7FFF_FFFF)
        begin
            r = 64'sh7FFF_FFFF;
            sat = 1'b1;
        end
        else if (r < -64'sh8000_0000)
        begin
            r = -64'sh8000_0000;
            sat = 1'b1;
        end
        return r;
    endfunction

    function automatic lerp_res_t predict_track(logic o, logic [5:0] idx, logic [31:0] t,
                                                logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z, logic [31:0] q);
        lerp_res_t r;
        int n;
        int s;
        longint span;
        longint offs;
        longint unsigned fm;
        bit fneg;
        bit sat;
        r = '{default: '0};
        sat = 1'b0;
        if (o == OP_WRITE)
        begin
            trk_time[idx] = t;
            trk_x[idx] = x;
            trk_y[idx] = y;
            trk_z[idx] = z;
            r.st = ST_WRITE_ACK;
            return r;
        end
        n = eff_count(trk_count);
        if (n == 1)
        begin
            r.x = trk_x[0];
            r.y = trk_y[0];
            r.z = trk_z[0];
            r.st = ST_SINGLE;
            return r;
        end
        s = 0;
        r.st = ST_FALLBACK;
        for (int i = 0; i + 1 < n; i++)
        begin
            if (q < trk_time[i + 1])
            begin
                s = i;
                r.st = ST_INTERP;
                break;
            end
        end
        span = longint'(trk_time[s + 1]) - longint'(trk_time[s]);
        r.seg = s;
        if (span == 0)
        begin
            r.x = trk_x[s];
            r.y = trk_y[s];
            r.z = trk_z[s];
            r.st = ST_ZERO_SPAN;
            return r;
        end
        offs = longint'(q) - longint'(trk_time[s]);
        fm = (longint'(offs < 0 ? -offs : offs) << FRAC_BITS) / (span < 0 ? -span : span);
        fneg = (offs < 0) != (span < 0);
        r.x = clip_lerp(longint'($signed(trk_x[s])), longint'($signed(trk_x[s + 1])), fm,
                        fneg, sat);
        r.y = clip_lerp(longint'($signed(trk_y[s])), longint'($signed(trk_y[s + 1])), fm,
                        fneg, sat);
        r.z = clip_lerp(longint'($signed(trk_z[s])), longint'($signed(trk_z[s + 1])), fm,
                        fneg, sat);
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch on result %0d: %s got %0h want %0h", checked, what, got, want);
    endtask

    // Sends one item in bursts; the expectation is queued once the item is taken.
    task automatic send_item(logic o, logic [5:0] idx, logic [31:0] t, logic [31:0] x,
                             logic [31:0] y, logic [31:0] z, logic [31:0] q,
                             bit typed, lerp_res_t given);
        lerp_res_t r;
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        push <= 1'b1;
        op <= o;
        key_index <= idx;
        key_time <= t;
        key_x <= x;
        key_y <= y;
        key_z <= z;
        query_time <= q;
        do
            @(posedge clk);
        while (full);
        burst_left--;
        r = predict_track(o, idx, t, x, y, z, q);
        if (o == OP_WRITE)
        begin
            slot_written[idx] = 1'b1;
            n_writes++;
        end
        else
            n_queries++;
        pending_res.insert(pending_res.size(), typed ? given : r);
    endtask

    // The register is only written once every queued item has produced its result.
    task automatic write_count(logic [KCNT_W-1:0] v);
        push <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        @(posedge clk);
        key_count_wr <= 1'b1;
        key_count <= v;
        @(posedge clk);
        key_count_wr <= 1'b0;
        trk_count = v;
        burst_left = 0;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1 << 19) - (1 << 18);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom_range(0, 1 << 24) - (1 << 23);
        endcase
    endfunction

    function automatic void add_row(bit cfg, logic o, logic [5:0] idx, logic [31:0] t,
                                    logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                    logic [31:0] q, bit typed, lerp_res_t r);
        dir_row_t row;
        row = '{cfg, o, idx, t, x, y, z, q, typed, r};
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 1_500_000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver steps through four stall patterns: always ready, random, rarely ready, periodic.
    always @(posedge clk)
    begin
        case ((cycles / 300) % 4)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 1) == 1);
            2: pop <= ($urandom_range(0, 7) == 0);
            default: pop <= ((cycles % 16) < 5);
        endcase
    end

    always @(posedge clk)
    begin
        lerp_res_t w;
        if (rst_n && pop && !empty)
        begin
            if (pending_res.size() == 0)
            begin
                report_mismatch("result with no item waiting for it", 0, 0);
            end
            else
            begin
                w = pending_res.pop_front();
                if (out_x !== w.x)
                    report_mismatch("out_x", out_x, w.x);
                if (out_y !== w.y)
                    report_mismatch("out_y", out_y, w.y);
                if (out_z !== w.z)
                    report_mismatch("out_z", out_z, w.z);
                if (segment !== w.seg)
                    report_mismatch("segment", segment, w.seg);
                if (status !== w.st)
                    report_mismatch("status", status, w.st);
                if (saturated !== w.sat)
                    report_mismatch("saturated", saturated, w.sat);
                checked++;
            end
        end
    end

    initial
    begin
        lerp_res_t none;
        lerp_res_t ack;
        lerp_res_t single;
        int n;
        int fill;
        int sent;
        int idx;
        logic [31:0] t;
        logic [31:0] q;
        logic [KCNT_W-1:0] count_plan [6];

        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        op = OP_WRITE;
        key_index = '0;
        key_time = '0;
        key_x = '0;
        key_y = '0;
        key_z = '0;
        query_time = '0;
        key_count_wr = 1'b0;
        key_count = 7'd1;
        errors = 0;
        checked = 0;
        n_queries = 0;
        n_writes = 0;
        burst_left = 0;
        cycles = 0;
        trk_count = 7'd1;
        foreach (slot_written[i])
            slot_written[i] = 1'b0;
        none = '{default: '0};
        ack = none;
        ack.st = ST_WRITE_ACK;
        single = none;
        single.x = 32'h7FFF_FFFF;
        single.y = 32'h8000_0000;
        single.z = 32'h0;
        single.st = ST_SINGLE;
        count_plan = '{7'd2, 7'd64, 7'd127, 7'd0, 7'd5, 7'd1};

        // Directed part: extremes, single key, fallback, extrapolation, zero span.
        add_row(0, OP_WRITE, 6'd0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0, 1, ack);
        add_row(0, OP_QUERY, 6'd0, 0, 0, 0, 0, 32'h0, 1, single);
        add_row(0, OP_QUERY, 6'd0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, single);
        add_row(0, OP_WRITE, 6'd1, 32'h1_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1_0000,
                0, 1, ack);
        add_row(0, OP_WRITE, 6'd2, 32'h2_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 0, 1, ack);
        add_row(0, OP_WRITE, 6'd3, 32'h2_0000, 32'h1234_5678, 32'hFFFF_0000, 32'h1,
                0, 1, ack);
        add_row(0, OP_WRITE, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF,
                0, 1, ack);
        add_row(1, OP_WRITE, 0, 7'd4, 0, 0, 0, 0, 0, none);
        add_row(0, OP_QUERY, 0, 0, 0, 0, 0, 32'h8000, 0, none);
        add_row(0, OP_QUERY, 0, 0, 0, 0, 0, 32'h1_8000, 0, none);
        add_row(0, OP_QUERY, 0, 0, 0, 0, 0, 32'h2_0000, 0, none);
        add_row(0, OP_QUERY, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, none);
        add_row(1, OP_WRITE, 0, 7'd0, 0, 0, 0, 0, 0, none);
        add_row(0, OP_QUERY, 0, 0, 0, 0, 0, 32'h5, 1, single);
        add_row(0, OP_WRITE, 6'd1, 32'h0, 32'h1, 32'h2, 32'h3, 0, 1, ack);
        add_row(1, OP_WRITE, 0, 7'd2, 0, 0, 0, 0, 0, none);
        add_row(0, OP_QUERY, 0, 0, 0, 0, 0, 32'h0, 0, none);
        add_row(0, OP_QUERY, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, none);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg)
                write_count(dir_rows[i].t[KCNT_W-1:0]);
            else
                send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].t, dir_rows[i].x,
                          dir_rows[i].y, dir_rows[i].z, dir_rows[i].q, dir_rows[i].typed,
                          dir_rows[i].res);
        end

        // Random part: mostly ordered tracks, some out-of-order and repeated times.
        for (sent = 0; sent < 600; sent++)
        begin
            if (sent % 90 == 0)
            begin
                if (sent / 90 < 6)
                    write_count(count_plan[sent / 90]);
                else
                    write_count($urandom_range(0, 127));
            end
            n = eff_count(trk_count);
            fill = -1;
            for (int i = n - 1; i >= 0; i--)
                if (!slot_written[i])
                    fill = i;
            if (fill < 0 && $urandom_range(0, 9) < 6)
            begin
                if ($urandom_range(0, 4) != 0)
                    q = $urandom_range(0, (n << 20) + (1 << 20));
                else
                    q = $urandom;
                send_item(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, q,
                          0, none);
            end
            else
            begin
                if (fill >= 0)
                    idx = fill;
                else if ($urandom_range(0, 3) != 0)
                    idx = $urandom_range(0, n - 1);
                else
                    idx = $urandom_range(0, 63);
                case ($urandom_range(0, 7))
                    0: t = $urandom;
                    1: t = (idx > 0 && slot_written[idx - 1]) ? trk_time[idx - 1] : 32'h0;
                    default: t = (idx << 20) + $urandom_range(0, (1 << 20) - 1);
                endcase
                send_item(OP_WRITE, idx, t, rand_value(), rand_value(), rand_value(),
                          $urandom, 0, none);
            end
        end

        push <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("%0d key writes and %0d queries sent, %0d results compared,",
                 n_writes, n_queries, checked);
        $display("track sizes from one key to the full store, with out-of-range counts.");
        if (errors == 0 && pending_res.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
